### hdl/kcrs_pkg.sv
// Shared types, register indexes and reset values for the key confirm/release setpoint control.
package kcrs_pkg;

   localparam int unsigned CodeWidth  = 6;
   localparam int unsigned SetWidth   = 16;
   localparam int unsigned CountWidth = 8;
   localparam int unsigned MapSlots   = 6;
   localparam int unsigned MapWidth   = MapSlots * CodeWidth;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = MapWidth;
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 48;

   // register indexes
   localparam logic [CsrAddrWidth-1:0] REG_VOLTAGE_STEP   = 3'd0;
   localparam logic [CsrAddrWidth-1:0] REG_VOLTAGE_MAX    = 3'd1;
   localparam logic [CsrAddrWidth-1:0] REG_CURRENT_STEP   = 3'd2;
   localparam logic [CsrAddrWidth-1:0] REG_CURRENT_MAX    = 3'd3;
   localparam logic [CsrAddrWidth-1:0] REG_PRESS_CONFIRM  = 3'd4;
   localparam logic [CsrAddrWidth-1:0] REG_RELEASE_FILTER = 3'd5;
   localparam logic [CsrAddrWidth-1:0] REG_KEY_MAP        = 3'd6;

   // key map slots, lowest bits first
   localparam int unsigned SLOT_VOLT_UP   = 0;
   localparam int unsigned SLOT_VOLT_DOWN = 1;
   localparam int unsigned SLOT_CUR_UP    = 2;
   localparam int unsigned SLOT_CUR_DOWN  = 3;
   localparam int unsigned SLOT_TOGGLE    = 4;
   localparam int unsigned SLOT_FAULT_RST = 5;

   localparam logic [SetWidth-1:0]   VOLTAGE_STEP_RST   = 16'd100;
   localparam logic [SetWidth-1:0]   VOLTAGE_MAX_RST    = 16'd30000;
   localparam logic [SetWidth-1:0]   CURRENT_STEP_RST   = 16'd10;
   localparam logic [SetWidth-1:0]   CURRENT_MAX_RST    = 16'd999;
   localparam logic [CountWidth-1:0] PRESS_CONFIRM_RST  = 8'd3;
   localparam logic [CountWidth-1:0] RELEASE_FILTER_RST = 8'd4;
   localparam logic [MapWidth-1:0]   KEY_MAP_RST        = '0;

   typedef struct packed {
      logic [SetWidth-1:0]   voltage_step;
      logic [SetWidth-1:0]   voltage_max;
      logic [SetWidth-1:0]   current_step;
      logic [SetWidth-1:0]   current_max;
      logic [CountWidth-1:0] press_confirm;
      logic [CountWidth-1:0] release_filter;
      logic [MapWidth-1:0]   key_map;
   } cfg_type;

   // debounce outcome handed to the setpoint stage and the result register
   typedef struct packed {
      logic                 confirmed;
      logic                 ready;
      logic [CodeWidth-1:0] held_key;
   } scan_type;

   typedef struct packed {
      logic [SetWidth-1:0] voltage_setpoint;
      logic [SetWidth-1:0] current_setpoint;
      logic                output_request;
      logic                fault_reset_pulse;
      logic                action_taken;
   } setp_type;

endpackage

### hdl/kcrs_debounce.sv
// Key debounce: startup idle qualification, press confirmation and release filter.
module kcrs_debounce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              mode,
   input  logic [kcrs_pkg::CodeWidth-1:0]    key_code,
   input  logic [kcrs_pkg::CountWidth-1:0]   press_confirm,
   input  logic [kcrs_pkg::CountWidth-1:0]   release_filter,
   output kcrs_pkg::scan_type                scan
);

   logic                            ready_flag_ff, ready_flag_in;
   logic [kcrs_pkg::CodeWidth-1:0]  latched_code_ff, latched_code_in;
   logic [kcrs_pkg::CountWidth-1:0] idle_run_ff, idle_run_in;
   logic [kcrs_pkg::CodeWidth-1:0]  cand_code_ff, cand_code_in;
   logic [kcrs_pkg::CountWidth-1:0] cand_run_ff, cand_run_in;
   logic [kcrs_pkg::CountWidth-1:0] idle_inc;
   logic [kcrs_pkg::CountWidth-1:0] run_inc;
   logic                            idle_hit;
   logic                            run_hit;
   logic                            confirmed;

   always_comb begin
      idle_inc = (idle_run_ff < release_filter) ? idle_run_ff + 8'd1 : idle_run_ff;
      idle_hit = (idle_inc >= release_filter);
      if (cand_code_ff != key_code) begin
         run_inc = 8'd1;
      end else if (cand_run_ff < press_confirm) begin
         run_inc = cand_run_ff + 8'd1;
      end else begin
         run_inc = cand_run_ff;
      end
      run_hit = (run_inc >= press_confirm);
   end

   always_comb begin
      ready_flag_in   = ready_flag_ff;
      latched_code_in = latched_code_ff;
      idle_run_in     = idle_run_ff;
      cand_code_in    = cand_code_ff;
      cand_run_in     = cand_run_ff;
      confirmed       = 1'b0;
      priority if (mode) begin
         // read error: drop candidate and idle run
         cand_code_in = '0;
         cand_run_in  = '0;
         idle_run_in  = '0;
      end else if (!ready_flag_ff || (latched_code_ff != '0)) begin
         cand_code_in = '0;
         cand_run_in  = '0;
         if (key_code == '0) begin
            idle_run_in = idle_hit ? '0 : idle_inc;
            if (idle_hit) begin
               latched_code_in = '0;
               ready_flag_in   = 1'b1;
            end
         end else begin
            idle_run_in = '0;
         end
      end else begin
         idle_run_in = '0;
         if (key_code == '0) begin
            cand_code_in = '0;
            cand_run_in  = '0;
         end else if (run_hit) begin
            latched_code_in = key_code;
            cand_code_in    = '0;
            cand_run_in     = '0;
            confirmed       = 1'b1;
         end else begin
            cand_code_in = key_code;
            cand_run_in  = run_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_flag_ff   <= 1'b0;
         latched_code_ff <= '0;
         idle_run_ff     <= '0;
         cand_code_ff    <= '0;
         cand_run_ff     <= '0;
      end else if (advance) begin
         ready_flag_ff   <= ready_flag_in;
         latched_code_ff <= latched_code_in;
         idle_run_ff     <= idle_run_in;
         cand_code_ff    <= cand_code_in;
         cand_run_ff     <= cand_run_in;
      end
   end

   assign scan.confirmed = confirmed;
   assign scan.ready     = ready_flag_in;
   assign scan.held_key  = latched_code_in;

`ifndef SYNTHESIS
   a_held_needs_ready: assert property (@(posedge clock) disable iff (reset)
      (latched_code_ff != '0) |-> ready_flag_ff)
      else $error("held key while not ready");

   a_cand_pair: assert property (@(posedge clock) disable iff (reset)
      ((cand_code_ff == '0) == (cand_run_ff == '0)))
      else $error("candidate code and run count disagree");

   a_confirm_latches: assert property (@(posedge clock) disable iff (reset)
      (advance && confirmed) |=> ((latched_code_ff != '0) && (cand_code_ff == '0)))
      else $error("confirmed key not latched");
`endif

endmodule

### hdl/kcrs_setpoint.sv
// Key map decode and saturating setpoint, output request and fault reset actions.
module kcrs_setpoint (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           fire,
   input  logic [kcrs_pkg::CodeWidth-1:0] key_code,
   input  logic                           supply_fault,
   input  kcrs_pkg::cfg_type              cfg,
   output kcrs_pkg::setp_type             setp
);

   logic [kcrs_pkg::SetWidth-1:0] volt_set_ff, volt_set_in;
   logic [kcrs_pkg::SetWidth-1:0] amp_set_ff, amp_set_in;
   logic                          out_req_ff, out_req_in;
   logic [kcrs_pkg::MapSlots-1:0] hit;
   logic [kcrs_pkg::MapSlots-1:0] first_hit;
   logic [kcrs_pkg::SetWidth:0]   volt_sum;
   logic [kcrs_pkg::SetWidth:0]   amp_sum;
   logic [kcrs_pkg::SetWidth-1:0] volt_up;
   logic [kcrs_pkg::SetWidth-1:0] volt_dn;
   logic [kcrs_pkg::SetWidth-1:0] amp_up;
   logic [kcrs_pkg::SetWidth-1:0] amp_dn;
   logic                          pulse;

   always_comb begin
      for (int i = 0; i < kcrs_pkg::MapSlots; i++) begin
         hit[i] = (cfg.key_map[i*kcrs_pkg::CodeWidth +: kcrs_pkg::CodeWidth] == key_code);
      end
      // lowest matching slot wins
      first_hit = hit & (~hit + 6'd1);
   end

   always_comb begin
      volt_sum = {1'b0, volt_set_ff} + {1'b0, cfg.voltage_step};
      amp_sum  = {1'b0, amp_set_ff} + {1'b0, cfg.current_step};
      volt_up  = (volt_sum > {1'b0, cfg.voltage_max}) ? cfg.voltage_max
                                                      : volt_sum[kcrs_pkg::SetWidth-1:0];
      amp_up   = (amp_sum > {1'b0, cfg.current_max}) ? cfg.current_max
                                                     : amp_sum[kcrs_pkg::SetWidth-1:0];
      volt_dn  = (volt_set_ff < cfg.voltage_step) ? '0 : volt_set_ff - cfg.voltage_step;
      amp_dn   = (amp_set_ff < cfg.current_step) ? '0 : amp_set_ff - cfg.current_step;
   end

   always_comb begin
      volt_set_in = volt_set_ff;
      amp_set_in  = amp_set_ff;
      out_req_in  = out_req_ff;
      pulse       = 1'b0;
      if (fire) begin
         if (first_hit[kcrs_pkg::SLOT_VOLT_UP])   volt_set_in = volt_up;
         if (first_hit[kcrs_pkg::SLOT_VOLT_DOWN]) volt_set_in = volt_dn;
         if (first_hit[kcrs_pkg::SLOT_CUR_UP])    amp_set_in  = amp_up;
         if (first_hit[kcrs_pkg::SLOT_CUR_DOWN])  amp_set_in  = amp_dn;
         if (first_hit[kcrs_pkg::SLOT_TOGGLE] && !supply_fault) out_req_in = !out_req_ff;
         if (first_hit[kcrs_pkg::SLOT_FAULT_RST]) pulse = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_set_ff <= '0;
         amp_set_ff  <= '0;
         out_req_ff  <= 1'b0;
      end else if (advance) begin
         volt_set_ff <= volt_set_in;
         amp_set_ff  <= amp_set_in;
         out_req_ff  <= out_req_in;
      end
   end

   assign setp.voltage_setpoint  = volt_set_in;
   assign setp.current_setpoint  = amp_set_in;
   assign setp.output_request    = out_req_in;
   assign setp.fault_reset_pulse = pulse;
   assign setp.action_taken      = fire && (hit != '0);

endmodule

### hdl/key_confirm_release_setpoint_ctl.sv
// Top level: request register, debounce and setpoint logic, response register, CSRs.
// A request accepted into the request register moves on to the response register, which
// drives rsp_tvalid, once that register is empty or its response is taken.
// Throughput: one request per cycle while rsp_tready is high; the response register frees
// the request register whenever the response is taken or empty.
// Reset clears all filter and setpoint state and loads the register reset values;
// the block accepts requests from the first cycle after reset.
module key_confirm_release_setpoint_ctl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] mode, [6:1] key_code, [7] supply fault flag
   input  logic [kcrs_pkg::ReqDataWidth-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] voltage_setpoint, [31:16] current_setpoint, [32] output_request,
   // [33] fault_reset_pulse, [34] key_confirmed, [35] action_taken,
   // [36] scan_ready, [42:37] held_key, [47:43] zero
   output logic [kcrs_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kcrs_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  logic [kcrs_pkg::CsrDataWidth-1:0]    csr_wdata
);

   kcrs_pkg::cfg_type                cfg_ff;
   logic                             in_valid_ff, in_valid_in;
   logic [kcrs_pkg::ReqDataWidth-1:0] in_data_ff;
   logic                             out_valid_ff, out_valid_in;
   logic [kcrs_pkg::RspDataWidth-1:0] rsp_data_ff, rsp_data_in;
   logic                             advance;
   logic                             req_take;
   kcrs_pkg::scan_type               scan;
   kcrs_pkg::setp_type               setp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.voltage_step   <= kcrs_pkg::VOLTAGE_STEP_RST;
         cfg_ff.voltage_max    <= kcrs_pkg::VOLTAGE_MAX_RST;
         cfg_ff.current_step   <= kcrs_pkg::CURRENT_STEP_RST;
         cfg_ff.current_max    <= kcrs_pkg::CURRENT_MAX_RST;
         cfg_ff.press_confirm  <= kcrs_pkg::PRESS_CONFIRM_RST;
         cfg_ff.release_filter <= kcrs_pkg::RELEASE_FILTER_RST;
         cfg_ff.key_map        <= kcrs_pkg::KEY_MAP_RST;
      end else if (csr_valid) begin
         unique case (csr_addr)
            kcrs_pkg::REG_VOLTAGE_STEP:   cfg_ff.voltage_step   <= csr_wdata[15:0];
            kcrs_pkg::REG_VOLTAGE_MAX:    cfg_ff.voltage_max    <= csr_wdata[15:0];
            kcrs_pkg::REG_CURRENT_STEP:   cfg_ff.current_step   <= csr_wdata[15:0];
            kcrs_pkg::REG_CURRENT_MAX:    cfg_ff.current_max    <= csr_wdata[15:0];
            kcrs_pkg::REG_PRESS_CONFIRM:  cfg_ff.press_confirm  <= csr_wdata[7:0];
            kcrs_pkg::REG_RELEASE_FILTER: cfg_ff.release_filter <= csr_wdata[7:0];
            kcrs_pkg::REG_KEY_MAP:        cfg_ff.key_map        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance the request register into the response register
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   kcrs_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .mode           (in_data_ff[0]),
      .key_code       (in_data_ff[6:1]),
      .press_confirm  (cfg_ff.press_confirm),
      .release_filter (cfg_ff.release_filter),
      .scan           (scan)
   );

   kcrs_setpoint u_setpoint (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .fire          (scan.confirmed),
      .key_code      (in_data_ff[6:1]),
      .supply_fault  (in_data_ff[7]),
      .cfg           (cfg_ff),
      .setp          (setp)
   );

   assign rsp_data_in = {5'b0, scan.held_key, scan.ready, setp.action_taken, scan.confirmed,
                         setp.fault_reset_pulse, setp.output_request,
                         setp.current_setpoint, setp.voltage_setpoint};

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### dv/key_confirm_release_setpoint_ctl_tb.sv
// Self-checking testbench for the key confirm/release setpoint controller.
`timescale 1ns / 1ps

module key_confirm_release_setpoint_ctl_tb;

   localparam int unsigned LIMIT_CYCLES   = 400000;
   localparam int unsigned RX_HOLD_CYCLES = 300;
   localparam int unsigned PHASE_SCANS    = 24;

   // key codes used by the directed part
   localparam logic [5:0] VUP_CODE  = 6'd39;
   localparam logic [5:0] VDN_CODE  = 6'd32;
   localparam logic [5:0] CUP_CODE  = 6'd1;
   localparam logic [5:0] CDN_CODE  = 6'd24;
   localparam logic [5:0] TGL_CODE  = 6'd16;
   localparam logic [5:0] FRST_CODE = 6'd8;
   localparam logic [5:0] DUP_CODE  = 6'd20;
   localparam logic [5:0] IDLE_CODE = 6'd0;

   typedef struct packed {
      logic       fault;
      logic [5:0] key;
      logic       read_err;
   } scan_item_type;

   typedef struct packed {
      logic [4:0]  pad;
      logic [5:0]  held_key;
      logic        scan_ready;
      logic        action_taken;
      logic        key_confirmed;
      logic        fault_reset_pulse;
      logic        output_request;
      logic [15:0] current_setpoint;
      logic [15:0] voltage_setpoint;
   } panel_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [kcrs_pkg::ReqDataWidth-1:0] req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [kcrs_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [kcrs_pkg::CsrAddrWidth-1:0] csr_addr = '0;
   logic [kcrs_pkg::CsrDataWidth-1:0] csr_wdata = '0;

   key_confirm_release_setpoint_ctl dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   scan_item_type    scan_q[$];
   panel_result_type setpoint_q[$];

   // register copies
   logic [15:0] cfg_vstep, cfg_vmax, cfg_istep, cfg_imax;
   logic [7:0]  cfg_press, cfg_release;
   logic [35:0] cfg_map;

   // filter and setpoint state
   logic        is_ready, out_on;
   logic [5:0]  held_code, cand_code;
   logic [7:0]  idle_count, cand_count;
   logic [15:0] volt_sp, amp_sp;

   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned queued = 0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned rx_hold_left = 0;
   bit          rx_hold_arm = 1'b0;
   bit          no_idle = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] sat_up(logic [15:0] v, logic [15:0] stp, logic [15:0] lim);
      logic [16:0] sum;
      sum = {1'b0, v} + {1'b0, stp};
      return (sum > {1'b0, lim}) ? lim : sum[15:0];
   endfunction

   function automatic logic [15:0] sat_down(logic [15:0] v, logic [15:0] stp);
      return (v < stp) ? 16'd0 : v - stp;
   endfunction

   // count one idle scan; true once the release filter is met
   function automatic bit idle_done();
      if (idle_count < cfg_release) idle_count++;
      if (idle_count >= cfg_release) begin
         idle_count = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic panel_result_type predict_scan(scan_item_type s);
      panel_result_type r;
      int slot;
      int i;
      r = '0;
      if (s.read_err) begin
         cand_code = '0;
         cand_count = '0;
         idle_count = '0;
      end else if (!is_ready) begin
         cand_code = '0;
         cand_count = '0;
         if (s.key == 0) begin
            if (idle_done()) begin
               held_code = '0;
               is_ready = 1'b1;
            end
         end else begin
            idle_count = '0;
         end
      end else if (held_code != 0) begin
         cand_code = '0;
         cand_count = '0;
         if (s.key == 0) begin
            if (idle_done()) held_code = '0;
         end else begin
            idle_count = '0;
         end
      end else begin
         idle_count = '0;
         if (s.key == 0) begin
            cand_code = '0;
            cand_count = '0;
         end else begin
            if (cand_code != s.key) begin
               cand_code = s.key;
               cand_count = 8'd1;
            end else if (cand_count < cfg_press) begin
               cand_count++;
            end
            if (cand_count >= cfg_press) begin
               held_code = s.key;
               cand_code = '0;
               cand_count = '0;
               r.key_confirmed = 1'b1;
               // first matching slot wins
               slot = -1;
               for (i = kcrs_pkg::MapSlots - 1; i >= 0; i--) begin
                  if (cfg_map[6*i +: 6] == s.key) slot = i;
               end
               r.action_taken = (slot >= 0);
               case (slot)
                  kcrs_pkg::SLOT_VOLT_UP:   volt_sp = sat_up(volt_sp, cfg_vstep, cfg_vmax);
                  kcrs_pkg::SLOT_VOLT_DOWN: volt_sp = sat_down(volt_sp, cfg_vstep);
                  kcrs_pkg::SLOT_CUR_UP:    amp_sp = sat_up(amp_sp, cfg_istep, cfg_imax);
                  kcrs_pkg::SLOT_CUR_DOWN:  amp_sp = sat_down(amp_sp, cfg_istep);
                  kcrs_pkg::SLOT_TOGGLE: begin
                     if (!s.fault) out_on = ~out_on;
                  end
                  kcrs_pkg::SLOT_FAULT_RST: r.fault_reset_pulse = 1'b1;
                  default: ;
               endcase
            end
         end
      end
      r.voltage_setpoint = volt_sp;
      r.current_setpoint = amp_sp;
      r.output_request   = out_on;
      r.scan_ready       = is_ready;
      r.held_key         = held_code;
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [47:0] want, logic [47:0] got);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %s: expected %0h, got %0h", what, want, got);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            setpoint_q.push_back(predict_scan(scan_q.pop_front()));
            send_gap = pick_gap();
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (scan_q.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= scan_q[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) rx_hold_left <= 0;
      else if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
      else if (rx_hold_arm) rx_hold_left <= RX_HOLD_CYCLES;
   end

   // response monitor
   always @(posedge clock) begin
      panel_result_type want, got;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (setpoint_q.size() == 0) begin
               flag_mismatch("response with no pending request", '0, rsp_tdata);
            end else begin
               want = setpoint_q.pop_front();
               if (got.voltage_setpoint !== want.voltage_setpoint)
                  flag_mismatch("voltage_setpoint", 48'(want.voltage_setpoint),
                                48'(got.voltage_setpoint));
               if (got.current_setpoint !== want.current_setpoint)
                  flag_mismatch("current_setpoint", 48'(want.current_setpoint),
                                48'(got.current_setpoint));
               if (got.output_request !== want.output_request)
                  flag_mismatch("output_request", 48'(want.output_request),
                                48'(got.output_request));
               if (got.fault_reset_pulse !== want.fault_reset_pulse)
                  flag_mismatch("fault_reset_pulse", 48'(want.fault_reset_pulse),
                                48'(got.fault_reset_pulse));
               if (got.key_confirmed !== want.key_confirmed)
                  flag_mismatch("key_confirmed", 48'(want.key_confirmed),
                                48'(got.key_confirmed));
               if (got.action_taken !== want.action_taken)
                  flag_mismatch("action_taken", 48'(want.action_taken),
                                48'(got.action_taken));
               if (got.scan_ready !== want.scan_ready)
                  flag_mismatch("scan_ready", 48'(want.scan_ready), 48'(got.scan_ready));
               if (got.held_key !== want.held_key)
                  flag_mismatch("held_key", 48'(want.held_key), 48'(got.held_key));
               if (got.pad !== want.pad)
                  flag_mismatch("padding bits", 48'(want.pad), 48'(got.pad));
            end
            recv_gap = pick_gap();
         end
         if (rx_hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("key_confirm_release_setpoint_ctl_tb NOT OK");
         $finish;
      end
   end

   task automatic write_reg(logic [kcrs_pkg::CsrAddrWidth-1:0] idx,
                            logic [kcrs_pkg::CsrDataWidth-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         kcrs_pkg::REG_VOLTAGE_STEP:   cfg_vstep = val[15:0];
         kcrs_pkg::REG_VOLTAGE_MAX:    cfg_vmax = val[15:0];
         kcrs_pkg::REG_CURRENT_STEP:   cfg_istep = val[15:0];
         kcrs_pkg::REG_CURRENT_MAX:    cfg_imax = val[15:0];
         kcrs_pkg::REG_PRESS_CONFIRM:  cfg_press = val[7:0];
         kcrs_pkg::REG_RELEASE_FILTER: cfg_release = val[7:0];
         kcrs_pkg::REG_KEY_MAP:        cfg_map = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_scan(bit err, logic [5:0] code, bit flt);
      scan_q.push_back('{fault: flt, key: code, read_err: err});
      queued++;
   endtask

   function automatic logic [5:0] rand_key();
      return 6'($urandom_range(1, 39));
   endfunction

   // hold until every request has come back, then let the pipeline settle
   task automatic drain();
      while (scan_q.size() != 0 || req_tvalid || setpoint_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_level(int unsigned typical);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return 16'($urandom());
         default: return 16'($urandom_range(0, typical));
      endcase
   endfunction

   function automatic logic [35:0] pick_map();
      logic [35:0] m;
      int unsigned i, r;
      m = '0;
      for (i = 0; i < kcrs_pkg::MapSlots; i++) begin
         r = $urandom_range(0, 19);
         if (r == 0) m[6*i +: 6] = '0;
         else if (r == 1 && i > 0) m[6*i +: 6] = m[6*(i-1) +: 6];
         else if (r == 2) m[6*i +: 6] = 6'($urandom_range(40, 63));
         else m[6*i +: 6] = rand_key();
      end
      return m;
   endfunction

   // idle run, then press; the press is sometimes short, and either part may be cut by a read error
   task automatic queue_press_cycle();
      int n, i;
      logic [5:0] code;
      n = int'(cfg_release) + $urandom_range(0, 2);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) queue_scan(1'b1, rand_key(), 1'($urandom()));
         else queue_scan(1'b0, IDLE_CODE, 1'($urandom()));
      end
      code = cfg_map[6*$urandom_range(0, kcrs_pkg::MapSlots - 1) +: 6];
      if (code == 0 || code > 39 || $urandom_range(0, 4) == 0) code = rand_key();
      n = int'(cfg_press) + $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) n = int'(cfg_press) - 1;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) queue_scan(1'b1, rand_key(), 1'($urandom()));
         else queue_scan(1'b0, code, 1'($urandom()));
      end
   endtask

   task automatic queue_noise();
      int n, i;
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) queue_scan(1'b1, 6'($urandom_range(0, 39)), 1'($urandom()));
         else if ($urandom_range(0, 1) == 0) queue_scan(1'b0, IDLE_CODE, 1'($urandom()));
         else queue_scan(1'b0, rand_key(), 1'($urandom()));
      end
   endtask

   initial begin
      int ph, i;
      cfg_vstep   = kcrs_pkg::VOLTAGE_STEP_RST;
      cfg_vmax    = kcrs_pkg::VOLTAGE_MAX_RST;
      cfg_istep   = kcrs_pkg::CURRENT_STEP_RST;
      cfg_imax    = kcrs_pkg::CURRENT_MAX_RST;
      cfg_press   = kcrs_pkg::PRESS_CONFIRM_RST;
      cfg_release = kcrs_pkg::RELEASE_FILTER_RST;
      cfg_map     = kcrs_pkg::KEY_MAP_RST;
      is_ready = 1'b0; out_on = 1'b0;
      held_code = '0; cand_code = '0;
      idle_count = '0; cand_count = '0;
      volt_sp = '0; amp_sp = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // startup with reset settings: read error and key break the idle run,
      // then an unmapped key confirms with an empty map
      queue_scan(1'b0, IDLE_CODE, 1'b0);
      queue_scan(1'b1, 6'd39, 1'b1);
      queue_scan(1'b0, 6'd7, 1'b0);
      for (i = 0; i < 4; i++) queue_scan(1'b0, IDLE_CODE, 1'b0);
      for (i = 0; i < 3; i++) queue_scan(1'b0, 6'd5, 1'b1);
      queue_scan(1'b1, IDLE_CODE, 1'b0);
      for (i = 0; i < 4; i++) queue_scan(1'b0, IDLE_CODE, 1'b0);
      drain();

      // every action at least once, at the setpoint extremes
      write_reg(kcrs_pkg::REG_VOLTAGE_STEP, 36'hFFFF);
      write_reg(kcrs_pkg::REG_VOLTAGE_MAX, 36'hFFFF);
      write_reg(kcrs_pkg::REG_CURRENT_STEP, 36'd1);
      write_reg(kcrs_pkg::REG_CURRENT_MAX, 36'd0);
      write_reg(kcrs_pkg::REG_PRESS_CONFIRM, 36'd1);
      write_reg(kcrs_pkg::REG_RELEASE_FILTER, 36'd1);
      write_reg(kcrs_pkg::REG_KEY_MAP,
                {FRST_CODE, TGL_CODE, CDN_CODE, CUP_CODE, VDN_CODE, VUP_CODE});
      no_idle = 1'b1;
      queue_scan(1'b0, VUP_CODE, 1'b1);  queue_scan(1'b0, IDLE_CODE, 1'b0);
      queue_scan(1'b0, VUP_CODE, 1'b0);  queue_scan(1'b0, IDLE_CODE, 1'b0);
      queue_scan(1'b0, VDN_CODE, 1'b0);  queue_scan(1'b0, IDLE_CODE, 1'b0);
      queue_scan(1'b0, CUP_CODE, 1'b0);  queue_scan(1'b0, IDLE_CODE, 1'b0);
      queue_scan(1'b0, CDN_CODE, 1'b0);  queue_scan(1'b0, IDLE_CODE, 1'b0);
      queue_scan(1'b0, TGL_CODE, 1'b0);  queue_scan(1'b0, IDLE_CODE, 1'b0);
      queue_scan(1'b0, TGL_CODE, 1'b1);  queue_scan(1'b0, IDLE_CODE, 1'b0);
      queue_scan(1'b0, FRST_CODE, 1'b0); queue_scan(1'b0, IDLE_CODE, 1'b1);
      drain();

      // zero thresholds, duplicate and zero map entries, setpoint above its limit
      no_idle = 1'b0;
      write_reg(kcrs_pkg::REG_PRESS_CONFIRM, 36'd0);
      write_reg(kcrs_pkg::REG_RELEASE_FILTER, 36'd0);
      write_reg(kcrs_pkg::REG_VOLTAGE_MAX, 36'd500);
      write_reg(kcrs_pkg::REG_KEY_MAP, {6'd23, DUP_CODE, 6'd22, 6'd21, 6'd0, DUP_CODE});
      queue_scan(1'b0, DUP_CODE, 1'b0); queue_scan(1'b0, IDLE_CODE, 1'b0);
      queue_scan(1'b0, DUP_CODE, 1'b0); queue_scan(1'b0, IDLE_CODE, 1'b0);
      drain();
      write_reg(kcrs_pkg::REG_VOLTAGE_MAX, 36'd100);
      queue_scan(1'b0, DUP_CODE, 1'b0); queue_scan(1'b0, IDLE_CODE, 1'b0);
      drain();

      for (ph = 0; ph < 9; ph++) begin
         write_reg(kcrs_pkg::REG_VOLTAGE_STEP, 36'(pick_level(3000)));
         write_reg(kcrs_pkg::REG_VOLTAGE_MAX, 36'(pick_level(40000)));
         write_reg(kcrs_pkg::REG_CURRENT_STEP, 36'(pick_level(200)));
         write_reg(kcrs_pkg::REG_CURRENT_MAX, 36'(pick_level(2000)));
         write_reg(kcrs_pkg::REG_PRESS_CONFIRM, 36'($urandom_range(1, 5)));
         write_reg(kcrs_pkg::REG_RELEASE_FILTER, 36'($urandom_range(1, 5)));
         write_reg(kcrs_pkg::REG_KEY_MAP, pick_map());
         no_idle = (ph % 3 == 1);
         if (ph == 4) begin
            // stall the response side while the queue keeps offering
            rx_hold_arm = 1'b1;
            repeat (2) @(negedge clock);
            rx_hold_arm = 1'b0;
         end
         queued = 0;
         while (queued < PHASE_SCANS) begin
            if ($urandom_range(0, 4) != 0) queue_press_cycle();
            else queue_noise();
         end
         drain();
      end

      // widest filters: a full press, then idle scans short of the release
      no_idle = 1'b0;
      write_reg(kcrs_pkg::REG_PRESS_CONFIRM, 36'd255);
      write_reg(kcrs_pkg::REG_RELEASE_FILTER, 36'd255);
      write_reg(kcrs_pkg::REG_KEY_MAP, {6'd0, 6'd33, 6'd0, 6'd0, 6'd0, 6'd0});
      for (i = 0; i < 256; i++) queue_scan(1'b0, 6'd33, 1'($urandom()));
      for (i = 0; i < 8; i++) queue_scan(1'b0, IDLE_CODE, 1'($urandom()));
      drain();

      repeat (8) @(negedge clock);
      if (mismatches == 0 && setpoint_q.size() == 0) begin
         $display("key_confirm_release_setpoint_ctl_tb OK");
      end else begin
         $display("key_confirm_release_setpoint_ctl_tb NOT OK");
      end
      $finish;
   end

endmodule

### key_confirm_release_setpoint_ctl.f
hdl/kcrs_pkg.sv
hdl/kcrs_debounce.sv
hdl/kcrs_setpoint.sv
hdl/key_confirm_release_setpoint_ctl.sv
dv/key_confirm_release_setpoint_ctl_tb.sv
